// ===== rtl/atilt_pkg.sv =====
// shared widths, types and the cordic stage angle table for the tilt angle core
`default_nettype none

package atilt_pkg;

  // configuration of the arctangent chain
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NUM_STAGES   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int STAGE_W      = $clog2(TABLE_LEN);

  // sample and square widths
  localparam int AXIS_W      = 16;
  localparam int AXIS_SHIFT  = 14;
  localparam int SQ_W        = 31;
  localparam int RAD_W       = SQ_W + 1;

  // square root: one result bit per cell, radicand is the sum times 2^28
  localparam int ROOT_W      = 30;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int REM_W       = ROOT_W + 2;

  // cordic vector and angle accumulator widths
  localparam int CW          = 34;
  localparam int AW          = 25;
  localparam int RND_W       = AW - 8;
  localparam int ANG_W       = 16;
  localparam int ANGLE_LIMIT = 23040;
  localparam logic signed [ANG_W-1:0] ANG_LIM = ANG_W'(ANGLE_LIMIT);

  // one word in the square root chain, three lanes side by side
  typedef struct packed {
    logic                          valid;
    logic signed [AXIS_W-1:0]      x;
    logic signed [AXIS_W-1:0]      y;
    logic signed [AXIS_W-1:0]      z;
    logic [2:0][RAD_W-1:0]         rad;
    logic [2:0][REM_W-1:0]         rem;
    logic [2:0][ROOT_W-1:0]        root;
  } sq_t;

  // one cordic lane: vector and angle accumulator
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
  } lane_t;

  // one word in the cordic chain with the special case flags
  typedef struct packed {
    logic            valid;
    logic            zero;
    logic            zneg;
    logic [2:0]      fz;
    logic [2:0]      fl;
    logic [2:0]      fneg;
    lane_t [2:0]     lane;
  } cd_t;

  // atan(2^-i) in degrees times 65536, rounded
  function automatic logic [AW-1:0] stage_angle(input logic [STAGE_W-1:0] idx);
    logic [AW-1:0] a;
    case (idx)
      5'd0:    a = AW'(2949120);
      5'd1:    a = AW'(1740967);
      5'd2:    a = AW'(919879);
      5'd3:    a = AW'(466945);
      5'd4:    a = AW'(234379);
      5'd5:    a = AW'(117304);
      5'd6:    a = AW'(58666);
      5'd7:    a = AW'(29335);
      5'd8:    a = AW'(14668);
      5'd9:    a = AW'(7334);
      5'd10:   a = AW'(3667);
      5'd11:   a = AW'(1833);
      5'd12:   a = AW'(917);
      5'd13:   a = AW'(458);
      5'd14:   a = AW'(229);
      5'd15:   a = AW'(115);
      5'd16:   a = AW'(57);
      5'd17:   a = AW'(29);
      5'd18:   a = AW'(14);
      5'd19:   a = AW'(7);
      5'd20:   a = AW'(4);
      5'd21:   a = AW'(2);
      5'd22:   a = AW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/accel_tilt_angles_core.sv =====
// tilt angle core: squares, square root cell chain, cordic cell chain, rounding
// path to out_valid: input, square, sum, sqrt cells, prep, cordic cells, output register
// throughput: one word per cycle; busy is always low and each chain cell moves every cycle
// the square root chain is 30 cells (one root bit each), the cordic chain one cell per stage
// reset (rst_n low, synchronous) clears every valid bit; words in flight are dropped
// results are shown for one cycle only, the receiver cannot stall the core
`default_nettype none

module accel_tilt_angles_core
  import atilt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [AXIS_W-1:0] in_acc_x,
  input  wire logic signed [AXIS_W-1:0] in_acc_y,
  input  wire logic signed [AXIS_W-1:0] in_acc_z,
  output logic                          out_valid,
  output logic signed [ANG_W-1:0]       out_angle_x,
  output logic signed [ANG_W-1:0]       out_angle_y,
  output logic signed [ANG_W-1:0]       out_angle_z,
  output logic                          out_zero_vector
);

  logic accept;

  logic                     in_valid_r;
  logic signed [AXIS_W-1:0] in_x_r, in_y_r, in_z_r;

  logic signed [2*AXIS_W-1:0] px, py, pz;
  logic                     sq_valid_r;
  logic signed [AXIS_W-1:0] sq_x_r, sq_y_r, sq_z_r;
  logic [SQ_W-1:0]          xx_r, yy_r, zz_r;

  logic                     sum_valid_r;
  logic signed [AXIS_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic [RAD_W-1:0]         s_yz_r, s_xz_r, s_xy_r;

  sq_t sq_chain [SQRT_STEPS+1];
  cd_t cd_chain [NUM_STAGES+1];

  sq_t                      sq_last;
  logic [AXIS_W:0]          zs, zabs;
  cd_t                      prep_r;
  cd_t                      prep_nxt;

  cd_t                      cd_last;
  logic signed [AW-1:0]     rnd   [3];
  logic signed [RND_W-1:0]  rsh   [3];
  logic signed [ANG_W-1:0]  sat   [3];
  logic signed [ANG_W-1:0]  fin   [3];

  logic                     out_valid_r;
  logic signed [ANG_W-1:0]  out_ax_r, out_ay_r, out_az_r;
  logic                     out_zero_r;

  // the core never holds off a word
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input word capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
      if (accept) begin
        in_x_r <= in_acc_x;
        in_y_r <= in_acc_y;
        in_z_r <= in_acc_z;
      end
    end
  end

  // squares of the three axes
  assign px = (2*AXIS_W)'(in_x_r) * (2*AXIS_W)'(in_x_r);
  assign py = (2*AXIS_W)'(in_y_r) * (2*AXIS_W)'(in_y_r);
  assign pz = (2*AXIS_W)'(in_z_r) * (2*AXIS_W)'(in_z_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else begin
      sq_valid_r <= in_valid_r;
      sq_x_r     <= in_x_r;
      sq_y_r     <= in_y_r;
      sq_z_r     <= in_z_r;
      xx_r       <= px[SQ_W-1:0];
      yy_r       <= py[SQ_W-1:0];
      zz_r       <= pz[SQ_W-1:0];
    end
  end

  // pairwise sums feeding the three root lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
    end else begin
      sum_valid_r <= sq_valid_r;
      sum_x_r     <= sq_x_r;
      sum_y_r     <= sq_y_r;
      sum_z_r     <= sq_z_r;
      s_yz_r      <= {1'b0, yy_r} + {1'b0, zz_r};
      s_xz_r      <= {1'b0, xx_r} + {1'b0, zz_r};
      s_xy_r      <= {1'b0, xx_r} + {1'b0, yy_r};
    end
  end

  // square root chain head
  always_comb begin
    sq_chain[0].valid = sum_valid_r;
    sq_chain[0].x     = sum_x_r;
    sq_chain[0].y     = sum_y_r;
    sq_chain[0].z     = sum_z_r;
    sq_chain[0].rad   = {s_xy_r, s_xz_r, s_yz_r};
    sq_chain[0].rem   = '0;
    sq_chain[0].root  = '0;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    atilt_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .sq_in  (sq_chain[k]),
      .sq_out (sq_chain[k+1])
    );
  end

  assign sq_last = sq_chain[SQRT_STEPS];

  // set up numerators, denominators and special case flags
  always_comb begin
    zs   = {sq_last.z[AXIS_W-1], sq_last.z};
    zabs = sq_last.z[AXIS_W-1] ? -zs : zs;

    prep_nxt.valid = sq_last.valid;
    prep_nxt.zero  = (sq_last.x == '0) && (sq_last.y == '0) && (sq_last.z == '0);
    prep_nxt.zneg  = sq_last.z[AXIS_W-1];

    // lane 0: x over magnitude of y,z
    prep_nxt.lane[0].x   = {{(CW - ROOT_W){1'b0}}, sq_last.root[0]};
    prep_nxt.lane[0].y   = {{(CW - AXIS_W - AXIS_SHIFT){sq_last.x[AXIS_W-1]}}, sq_last.x,
                            {AXIS_SHIFT{1'b0}}};
    prep_nxt.lane[0].acc = '0;
    prep_nxt.fz[0]       = (sq_last.x == '0);
    prep_nxt.fl[0]       = (sq_last.root[0] == '0);
    prep_nxt.fneg[0]     = sq_last.x[AXIS_W-1];

    // lane 1: y over magnitude of x,z
    prep_nxt.lane[1].x   = {{(CW - ROOT_W){1'b0}}, sq_last.root[1]};
    prep_nxt.lane[1].y   = {{(CW - AXIS_W - AXIS_SHIFT){sq_last.y[AXIS_W-1]}}, sq_last.y,
                            {AXIS_SHIFT{1'b0}}};
    prep_nxt.lane[1].acc = '0;
    prep_nxt.fz[1]       = (sq_last.y == '0);
    prep_nxt.fl[1]       = (sq_last.root[1] == '0);
    prep_nxt.fneg[1]     = sq_last.y[AXIS_W-1];

    // lane 2: magnitude of x,y over |z|, sign restored at the end
    prep_nxt.lane[2].x   = {{(CW - AXIS_W - 1 - AXIS_SHIFT){1'b0}}, zabs, {AXIS_SHIFT{1'b0}}};
    prep_nxt.lane[2].y   = {{(CW - ROOT_W){1'b0}}, sq_last.root[2]};
    prep_nxt.lane[2].acc = '0;
    prep_nxt.fz[2]       = (sq_last.root[2] == '0);
    prep_nxt.fl[2]       = (sq_last.z == '0);
    prep_nxt.fneg[2]     = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.valid <= 1'b0;
    end else begin
      prep_r <= prep_nxt;
    end
  end

  // cordic chain
  assign cd_chain[0] = prep_r;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cordic
    atilt_cordic_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .stage  (STAGE_W'(k)),
      .cd_in  (cd_chain[k]),
      .cd_out (cd_chain[k+1])
    );
  end

  assign cd_last = cd_chain[NUM_STAGES];

  // round to 1/256 degree, saturate, apply special cases
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rnd[l] = cd_last.lane[l].acc + AW'(128);
      rsh[l] = RND_W'(rnd[l] >>> 8);
      if (rsh[l] > RND_W'(ANGLE_LIMIT)) begin
        sat[l] = ANG_LIM;
      end else if (rsh[l] < -RND_W'(ANGLE_LIMIT)) begin
        sat[l] = -ANG_LIM;
      end else begin
        sat[l] = rsh[l][ANG_W-1:0];
      end
      if (cd_last.fz[l]) begin
        fin[l] = '0;
      end else if (cd_last.fl[l]) begin
        fin[l] = cd_last.fneg[l] ? -ANG_LIM : ANG_LIM;
      end else begin
        fin[l] = sat[l];
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cd_last.valid;
      out_ax_r    <= fin[0];
      out_ay_r    <= fin[1];
      out_az_r    <= cd_last.zneg ? -fin[2] : fin[2];
      out_zero_r  <= cd_last.zero;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_angle_x     = out_ax_r;
  assign out_angle_y     = out_ay_r;
  assign out_angle_z     = out_az_r;
  assign out_zero_vector = out_zero_r;

endmodule

`default_nettype wire

// ===== rtl/atilt_sqrt_cell.sv =====
// one square root cell: settles one root bit on each of three lanes
`default_nettype none

module atilt_sqrt_cell
  import atilt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sq_t  sq_in,
  output sq_t       sq_out
);

  sq_t sq_r;
  sq_t sq_nxt;
  logic [REM_W+1:0] cur   [3];
  logic [REM_W+1:0] trial [3];

  // restoring digit step: bring in two radicand bits, try root*4+1
  always_comb begin
    sq_nxt = sq_in;
    for (int l = 0; l < 3; l++) begin
      cur[l]   = {sq_in.rem[l], sq_in.rad[l][RAD_W-1 -: 2]};
      trial[l] = {{(REM_W - ROOT_W){1'b0}}, sq_in.root[l], 2'b01};
      sq_nxt.rad[l] = {sq_in.rad[l][RAD_W-3:0], 2'b00};
      if (cur[l] >= trial[l]) begin
        sq_nxt.rem[l]  = REM_W'(cur[l] - trial[l]);
        sq_nxt.root[l] = {sq_in.root[l][ROOT_W-2:0], 1'b1};
      end else begin
        sq_nxt.rem[l]  = cur[l][REM_W-1:0];
        sq_nxt.root[l] = {sq_in.root[l][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.valid <= 1'b0;
    end else begin
      sq_r <= sq_nxt;
    end
  end

  assign sq_out = sq_r;

endmodule

`default_nettype wire

// ===== rtl/atilt_cordic_cell.sv =====
// one cordic vectoring cell: a micro-rotation on each of three lanes
`default_nettype none

module atilt_cordic_cell
  import atilt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [STAGE_W-1:0] stage,
  input  wire cd_t                cd_in,
  output cd_t                     cd_out
);

  cd_t cd_r;
  cd_t cd_nxt;
  logic [AW-1:0]        ang;
  logic signed [CW-1:0] xv [3];
  logic signed [CW-1:0] yv [3];
  logic signed [CW-1:0] dx [3];
  logic signed [CW-1:0] dy [3];

  assign ang = stage_angle(stage);

  // rotate toward the x axis, accumulate the stage angle
  always_comb begin
    cd_nxt = cd_in;
    for (int l = 0; l < 3; l++) begin
      xv[l] = cd_in.lane[l].x;
      yv[l] = cd_in.lane[l].y;
      dx[l] = yv[l] >>> stage;
      dy[l] = xv[l] >>> stage;
      if (!yv[l][CW-1]) begin
        cd_nxt.lane[l].x   = xv[l] + dx[l];
        cd_nxt.lane[l].y   = yv[l] - dy[l];
        cd_nxt.lane[l].acc = cd_in.lane[l].acc + $signed(ang);
      end else begin
        cd_nxt.lane[l].x   = xv[l] - dx[l];
        cd_nxt.lane[l].y   = yv[l] + dy[l];
        cd_nxt.lane[l].acc = cd_in.lane[l].acc - $signed(ang);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r.valid <= 1'b0;
    end else begin
      cd_r <= cd_nxt;
    end
  end

  assign cd_out = cd_r;

endmodule

`default_nettype wire
